[hw/rtl/ibcgi_pkg.sv]
// ----------------------------------------------------------------------------
// ibcgi_pkg
// Shared types and constants for the imu bias calibration and gyro integrator.
// ----------------------------------------------------------------------------
package ibcgi_pkg;

  localparam int unsigned AccW    = 14;
  localparam int unsigned RawW    = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned DtW     = 32;
  localparam int unsigned AOffW   = 24;
  localparam int unsigned GOffW   = 25;
  localparam int unsigned SumW    = 34;
  localparam int unsigned AngleW  = 64;
  localparam int unsigned CorrW   = 23;
  localparam int unsigned RateW   = 26;
  localparam int unsigned ProdW   = RateW + DtW + 1;
  localparam int unsigned NumW    = 43;
  localparam int unsigned DivDW   = 42;
  localparam int unsigned DivSW   = CountW + 1;
  localparam int unsigned DivQW   = 25;
  localparam int unsigned AxisW   = 3;

  localparam logic [20:0] OneGQ8 = 21'd1049180;
  localparam logic signed [24:0] CorrMax = 25'sd4194303;
  localparam logic signed [24:0] CorrMin = -25'sd4194304;

  localparam logic [AxisW-1:0] AxisAz       = 3'd2;
  localparam logic [AxisW-1:0] AxisLastDiv  = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL,
    S_ADD,
    S_OUT,
    S_DIV_PREP,
    S_DIV_START,
    S_DIV_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic start_calib;
    logic drop_first;
    logic calib_add;
    logic axis_clr;
    logic axis_inc;
    logic mul;
    logic add;
    logic div_prep;
    logic div_start;
    logic div_store;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cmd;
    logic first_pending;
    logic calib_active;
    logic calib_last;
    logic axis_last_angle;
    logic axis_last_div;
    logic div_done;
    logic div_busy;
    logic out_busy;
  } ctrl_sts_t;

endpackage

[hw/rtl/ibcgi_div.sv]
// ----------------------------------------------------------------------------
// ibcgi_div
// Restoring divider, one quotient bit per cycle, for offset computation.
// ----------------------------------------------------------------------------
module ibcgi_div import ibcgi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivDW-1:0] dividend_i,
  input  logic [DivSW-1:0] divisor_i,
  output logic [DivQW-1:0] quotient_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam int unsigned CntW = $clog2(DivQW);
  localparam logic [CntW-1:0] CntLast = CntW'(DivQW - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DivSW-1:0] rem_q, rem_d;
  logic [DivQW-1:0] quo_q, quo_d;
  logic [DivSW-1:0] dsr_q, dsr_d;
  logic [DivSW+1:0] trial;

  assign trial = {1'b0, rem_q, quo_q[DivQW-1]} - {2'b00, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = '0;
      rem_d  = dividend_i[DivDW-1:DivQW];
      quo_d  = dividend_i[DivQW-1:0];
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DivSW+1]) begin
        rem_d = trial[DivSW-1:0];
        quo_d = {quo_q[DivQW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DivSW-2:0], quo_q[DivQW-1]};
        quo_d = {quo_q[DivQW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;
  assign done_o     = done_q;

endmodule

[hw/rtl/ibcgi_ctrl.sv]
// ----------------------------------------------------------------------------
// ibcgi_ctrl
// Sequencer for sample handling, calibration finish and result hand-off.
// ----------------------------------------------------------------------------
module ibcgi_ctrl import ibcgi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.cmd) begin
          cmd_o.start_calib = 1'b1;
          state_d           = S_IDLE;
        end else if (sts_i.first_pending) begin
          cmd_o.drop_first = 1'b1;
          state_d          = S_IDLE;
        end else if (sts_i.calib_active) begin
          cmd_o.calib_add = 1'b1;
          if (sts_i.calib_last) begin
            cmd_o.axis_clr = 1'b1;
            state_d        = S_DIV_PREP;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.axis_clr = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        if (sts_i.axis_last_angle) begin
          state_d = S_OUT;
        end else begin
          cmd_o.axis_inc = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DIV_PREP: begin
        cmd_o.div_prep = 1'b1;
        state_d        = S_DIV_START;
      end
      S_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts_i.div_done && !sts_i.div_busy) begin
          cmd_o.div_store = 1'b1;
          if (sts_i.axis_last_div) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.axis_inc = 1'b1;
            state_d        = S_DIV_PREP;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/ibcgi_datapath.sv]
// ----------------------------------------------------------------------------
// ibcgi_datapath
// Sample capture, calibration sums, offsets, angle accumulators and outputs.
// ----------------------------------------------------------------------------
module ibcgi_datapath import ibcgi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output ctrl_sts_t                sts_o,
  input  logic                     cmd_in_i,
  input  logic [CountW-1:0]        calib_count_i,
  input  logic signed [RawW-1:0]   accel_x_raw_i,
  input  logic signed [RawW-1:0]   accel_y_raw_i,
  input  logic signed [RawW-1:0]   accel_z_raw_i,
  input  logic signed [RawW-1:0]   gyro_x_raw_i,
  input  logic signed [RawW-1:0]   gyro_y_raw_i,
  input  logic signed [RawW-1:0]   gyro_z_raw_i,
  input  logic [DtW-1:0]           elapsed_us_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [CorrW-1:0]  accel_x_corr_o,
  output logic signed [CorrW-1:0]  accel_y_corr_o,
  output logic signed [CorrW-1:0]  accel_z_corr_o,
  output logic signed [AngleW-1:0] angle_x_o,
  output logic signed [AngleW-1:0] angle_y_o,
  output logic signed [AngleW-1:0] angle_z_o
);

  // captured transaction
  logic                    cmd_q;
  logic [CountW-1:0]       count_q;
  logic signed [AccW-1:0]  acc_q [3];
  logic signed [RawW-1:0]  gyr_q [3];
  logic [DtW-1:0]          dt_q;

  // calibration and integration state
  logic signed [AOffW-1:0]  aoff_q [3];
  logic signed [GOffW-1:0]  goff_q [3];
  logic signed [SumW-1:0]   sum_q  [6];
  logic [AngleW-1:0]        angle_q [3];
  logic [CountW-1:0]        remain_q;
  logic [CountW-1:0]        total_q;
  logic                     first_q;
  logic [AxisW-1:0]         axis_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [NumW-1:0]   num_q;

  // result registers
  logic                     out_valid_q;
  logic signed [CorrW-1:0]  corr_q  [3];
  logic [AngleW-1:0]        oang_q  [3];

  logic signed [CorrW-1:0]  corr    [3];
  logic signed [RateW-1:0]  rate;
  logic signed [SumW-1:0]   sum_sel;
  logic signed [NumW-1:0]   num;
  logic [NumW-1:0]          mag;
  logic [DivDW-1:0]         dividend;
  logic [DivQW-1:0]         quotient;
  logic                     div_busy;
  logic                     div_done;
  logic signed [24:0]       cdiff [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cdiff[k] = 25'(signed'({acc_q[k], 8'h00})) - 25'(aoff_q[k]);
      if (cdiff[k] > CorrMax) begin
        corr[k] = CorrMax[CorrW-1:0];
      end else if (cdiff[k] < CorrMin) begin
        corr[k] = CorrMin[CorrW-1:0];
      end else begin
        corr[k] = cdiff[k][CorrW-1:0];
      end
    end
  end

  assign rate = RateW'(signed'({gyr_q[axis_q[1:0]], 8'h00})) - RateW'(goff_q[axis_q[1:0]]);

  always_comb begin
    case (axis_q)
      3'd0:    sum_sel = sum_q[0];
      3'd1:    sum_sel = sum_q[1];
      3'd2:    sum_sel = sum_q[2];
      3'd3:    sum_sel = sum_q[3];
      3'd4:    sum_sel = sum_q[4];
      3'd5:    sum_sel = sum_q[5];
      default: sum_sel = '0;
    endcase
  end

  always_comb begin
    num = NumW'(signed'({sum_sel, 8'h00}));
    if (axis_q == AxisAz) begin
      num = num - signed'(NumW'(total_q * OneGQ8));
    end
  end

  assign mag      = num_q[NumW-1] ? NumW'(-num_q) : NumW'(num_q);
  assign dividend = {mag[DivDW-2:0], 1'b0} + DivDW'(total_q);

  ibcgi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  ({total_q, 1'b0}),
    .quotient_o (quotient),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= cmd_in_i;
      count_q  <= calib_count_i;
      acc_q[0] <= accel_x_raw_i[RawW-1:2];
      acc_q[1] <= accel_y_raw_i[RawW-1:2];
      acc_q[2] <= accel_z_raw_i[RawW-1:2];
      gyr_q[0] <= gyro_x_raw_i;
      gyr_q[1] <= gyro_y_raw_i;
      gyr_q[2] <= gyro_z_raw_i;
      dt_q     <= elapsed_us_i;
    end
    if (cmd_i.mul) begin
      prod_q <= rate * signed'({1'b0, dt_q});
    end
    if (cmd_i.div_prep) begin
      num_q <= num;
    end
    if (cmd_i.out_load) begin
      for (int k = 0; k < 3; k++) begin
        corr_q[k] <= corr[k];
        oang_q[k] <= angle_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        aoff_q[k]  <= '0;
        goff_q[k]  <= '0;
        angle_q[k] <= '0;
      end
      for (int k = 0; k < 6; k++) begin
        sum_q[k] <= '0;
      end
      remain_q    <= '0;
      total_q     <= '0;
      first_q     <= 1'b1;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start_calib) begin
        for (int k = 0; k < 3; k++) begin
          aoff_q[k] <= '0;
          goff_q[k] <= '0;
        end
        for (int k = 0; k < 6; k++) begin
          sum_q[k] <= '0;
        end
        remain_q <= count_q;
        total_q  <= count_q;
      end
      if (cmd_i.drop_first) begin
        first_q <= 1'b0;
      end
      if (cmd_i.calib_add) begin
        for (int k = 0; k < 3; k++) begin
          sum_q[k]     <= sum_q[k] + SumW'(acc_q[k]);
          sum_q[k + 3] <= sum_q[k + 3] + SumW'(gyr_q[k]);
        end
        remain_q <= remain_q - 1'b1;
      end
      if (cmd_i.axis_clr) begin
        axis_q <= '0;
      end else if (cmd_i.axis_inc) begin
        axis_q <= axis_q + 1'b1;
      end
      if (cmd_i.add) begin
        angle_q[axis_q[1:0]] <= angle_q[axis_q[1:0]] + AngleW'(prod_q);
      end
      if (cmd_i.div_store) begin
        case (axis_q)
          3'd0:    aoff_q[0] <= num_q[NumW-1] ? -AOffW'(quotient) : AOffW'(quotient);
          3'd1:    aoff_q[1] <= num_q[NumW-1] ? -AOffW'(quotient) : AOffW'(quotient);
          3'd2:    aoff_q[2] <= num_q[NumW-1] ? -AOffW'(quotient) : AOffW'(quotient);
          3'd3:    goff_q[0] <= num_q[NumW-1] ? -GOffW'(quotient) : GOffW'(quotient);
          3'd4:    goff_q[1] <= num_q[NumW-1] ? -GOffW'(quotient) : GOffW'(quotient);
          3'd5:    goff_q[2] <= num_q[NumW-1] ? -GOffW'(quotient) : GOffW'(quotient);
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.cmd             = cmd_q;
    sts_o.first_pending   = first_q;
    sts_o.calib_active    = remain_q != '0;
    sts_o.calib_last      = remain_q == CountW'(1);
    sts_o.axis_last_angle = axis_q == AxisAz;
    sts_o.axis_last_div   = axis_q == AxisLastDiv;
    sts_o.div_done        = div_done;
    sts_o.div_busy        = div_busy;
    sts_o.out_busy        = out_valid_q && !out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign accel_x_corr_o = corr_q[0];
  assign accel_y_corr_o = corr_q[1];
  assign accel_z_corr_o = corr_q[2];
  assign angle_x_o      = signed'(oang_q[0]);
  assign angle_y_o      = signed'(oang_q[1]);
  assign angle_z_o      = signed'(oang_q[2]);

endmodule

[hw/rtl/imu_bias_calibrate_and_gyro_integrate_unit.sv]
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_gyro_integrate_unit
// Accelerometer and gyro bias calibration with 64-bit gyro angle integration.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A start command, the dropped first
// sample and each calibration sample but the last go through the decide state
// and back to idle. A normal sample goes through the multiply and accumulate
// states before its result is registered: the three angle updates share one
// multiplier, with a multiply step and an accumulate step per axis. For the
// last calibration sample the six offsets go one after another through a
// restoring divider that produces one quotient bit per cycle, with prepare and
// start states per offset. A finished result waits in the output register; a
// following normal sample stalls only at its own hand-off.
module imu_bias_calibrate_and_gyro_integrate_unit import ibcgi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic [CountW-1:0]        calib_count_i,
  input  logic signed [RawW-1:0]   accel_x_raw_i,
  input  logic signed [RawW-1:0]   accel_y_raw_i,
  input  logic signed [RawW-1:0]   accel_z_raw_i,
  input  logic signed [RawW-1:0]   gyro_x_raw_i,
  input  logic signed [RawW-1:0]   gyro_y_raw_i,
  input  logic signed [RawW-1:0]   gyro_z_raw_i,
  input  logic [DtW-1:0]           elapsed_us_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CorrW-1:0]  accel_x_corr_o,
  output logic signed [CorrW-1:0]  accel_y_corr_o,
  output logic signed [CorrW-1:0]  accel_z_corr_o,
  output logic signed [AngleW-1:0] angle_x_o,
  output logic signed [AngleW-1:0] angle_y_o,
  output logic signed [AngleW-1:0] angle_z_o
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  ibcgi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  ibcgi_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .sts_o          (ctrl_sts),
    .cmd_in_i       (cmd_i),
    .calib_count_i  (calib_count_i),
    .accel_x_raw_i  (accel_x_raw_i),
    .accel_y_raw_i  (accel_y_raw_i),
    .accel_z_raw_i  (accel_z_raw_i),
    .gyro_x_raw_i   (gyro_x_raw_i),
    .gyro_y_raw_i   (gyro_y_raw_i),
    .gyro_z_raw_i   (gyro_z_raw_i),
    .elapsed_us_i   (elapsed_us_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .accel_x_corr_o (accel_x_corr_o),
    .accel_y_corr_o (accel_y_corr_o),
    .accel_z_corr_o (accel_z_corr_o),
    .angle_x_o      (angle_x_o),
    .angle_y_o      (angle_y_o),
    .angle_z_o      (angle_z_o)
  );

  // no new transaction while offsets are being computed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_sts.div_busy |-> !in_ready_o)
    else $error("input ready during offset division");

  // a result is only produced outside calibration and after the first sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.out_load |-> (!ctrl_sts.calib_active && !ctrl_sts.first_pending))
    else $error("result produced during calibration or for first sample");

  // a start command never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i) |=> !ctrl_cmd.out_load ##1 !ctrl_cmd.out_load)
    else $error("start command produced a result");

endmodule

[tb/imu_bias_calibrate_and_gyro_integrate_unit_tb.sv]
// ----------------------------------------------------------------------------
// imu_bias_calibrate_and_gyro_integrate_unit_tb
// Self-checking testbench for the imu bias calibration and gyro integrator.
// A behavioral model tracks offsets, calibration sums and angle accumulators
// and predicts every result. Directed tests cover the dropped first sample,
// field extremes, zero-count and restarted calibrations and saturation. Random
// traffic then runs under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module imu_bias_calibrate_and_gyro_integrate_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ibcgi_pkg::*;

  localparam logic   CmdSample     = 1'b0;
  localparam logic   CmdStart      = 1'b1;
  localparam longint Q8Scale       = 256;
  localparam int     WatchdogLimit = 5000;
  localparam int     TailCycles    = 200;
  localparam int     ReportLimit   = 10;

  typedef struct packed {
    logic                   cmd;
    logic [CountW-1:0]      count;
    logic signed [RawW-1:0] ax;
    logic signed [RawW-1:0] ay;
    logic signed [RawW-1:0] az;
    logic signed [RawW-1:0] gx;
    logic signed [RawW-1:0] gy;
    logic signed [RawW-1:0] gz;
    logic [DtW-1:0]         dt;
  } imu_item_t;

  typedef struct packed {
    logic [CorrW-1:0]  ax;
    logic [CorrW-1:0]  ay;
    logic [CorrW-1:0]  az;
    logic [AngleW-1:0] ang_x;
    logic [AngleW-1:0] ang_y;
    logic [AngleW-1:0] ang_z;
  } imu_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     cmd_i = CmdSample;
  logic [CountW-1:0]        calib_count_i = '0;
  logic signed [RawW-1:0]   accel_x_raw_i = '0;
  logic signed [RawW-1:0]   accel_y_raw_i = '0;
  logic signed [RawW-1:0]   accel_z_raw_i = '0;
  logic signed [RawW-1:0]   gyro_x_raw_i = '0;
  logic signed [RawW-1:0]   gyro_y_raw_i = '0;
  logic signed [RawW-1:0]   gyro_z_raw_i = '0;
  logic [DtW-1:0]           elapsed_us_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [CorrW-1:0]  accel_x_corr_o;
  logic signed [CorrW-1:0]  accel_y_corr_o;
  logic signed [CorrW-1:0]  accel_z_corr_o;
  logic signed [AngleW-1:0] angle_x_o;
  logic signed [AngleW-1:0] angle_y_o;
  logic signed [AngleW-1:0] angle_z_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  // model state
  longint      accel_bias[3];
  longint      gyro_bias[3];
  longint      bias_sum[6];
  bit [63:0]   angle_total[3];
  int unsigned calib_left = 0;
  int unsigned calib_len = 0;
  bit          drop_pending = 1'b1;
  imu_result_t integ_q[$];

  imu_bias_calibrate_and_gyro_integrate_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .calib_count_i  (calib_count_i),
    .accel_x_raw_i  (accel_x_raw_i),
    .accel_y_raw_i  (accel_y_raw_i),
    .accel_z_raw_i  (accel_z_raw_i),
    .gyro_x_raw_i   (gyro_x_raw_i),
    .gyro_y_raw_i   (gyro_y_raw_i),
    .gyro_z_raw_i   (gyro_z_raw_i),
    .elapsed_us_i   (elapsed_us_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .accel_x_corr_o (accel_x_corr_o),
    .accel_y_corr_o (accel_y_corr_o),
    .accel_z_corr_o (accel_z_corr_o),
    .angle_x_o      (angle_x_o),
    .angle_y_o      (angle_y_o),
    .angle_z_o      (angle_z_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic void step_imu_model(imu_item_t it);
    logic signed [RawW-1:0] araw[3];
    logic signed [RawW-1:0] graw[3];
    longint                 acc[3];
    longint                 gyr[3];
    longint                 corr;
    longint                 rate;
    longint                 num;
    logic [CorrW-1:0]       cv[3];
    imu_result_t            res;
    araw = '{it.ax, it.ay, it.az};
    graw = '{it.gx, it.gy, it.gz};
    if (it.cmd == CmdStart) begin
      for (int k = 0; k < 3; k++) begin
        accel_bias[k] = 0;
        gyro_bias[k] = 0;
      end
      for (int k = 0; k < 6; k++) begin
        bias_sum[k] = 0;
      end
      calib_left = it.count;
      calib_len = it.count;
      return;
    end
    if (drop_pending) begin
      drop_pending = 1'b0;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      acc[k] = longint'(araw[k] >>> 2);
      gyr[k] = longint'(graw[k]);
    end
    if (calib_left > 0) begin
      for (int k = 0; k < 3; k++) begin
        bias_sum[k] += acc[k];
        bias_sum[k+3] += gyr[k];
      end
      calib_left--;
      if (calib_left == 0) begin
        for (int k = 0; k < 3; k++) begin
          num = bias_sum[k] * Q8Scale;
          // z carries one g while at rest
          if (k == 2) begin
            num -= longint'(calib_len) * longint'(OneGQ8);
          end
          accel_bias[k] = div_nearest(num, longint'(calib_len));
          gyro_bias[k] = div_nearest(bias_sum[k+3] * Q8Scale, longint'(calib_len));
        end
      end
      return;
    end
    for (int k = 0; k < 3; k++) begin
      corr = acc[k] * Q8Scale - accel_bias[k];
      if (corr > longint'(CorrMax)) begin
        corr = longint'(CorrMax);
      end
      if (corr < longint'(CorrMin)) begin
        corr = longint'(CorrMin);
      end
      cv[k] = corr[CorrW-1:0];
      rate = gyr[k] * Q8Scale - gyro_bias[k];
      angle_total[k] = angle_total[k] + 64'(rate * longint'(it.dt));
    end
    res = '{cv[0], cv[1], cv[2], angle_total[0], angle_total[1], angle_total[2]};
    integ_q.push_back(res);
  endfunction

  function automatic imu_item_t sample_item(logic signed [RawW-1:0] ax, ay, az, gx, gy, gz,
                                            logic [DtW-1:0] dt);
    imu_item_t it;
    it = '{CmdSample, CountW'($urandom), ax, ay, az, gx, gy, gz, dt};
    return it;
  endfunction

  function automatic imu_item_t start_item(logic [CountW-1:0] n);
    imu_item_t it;
    it = '{CmdStart, n, RawW'($urandom), RawW'($urandom), RawW'($urandom),
           RawW'($urandom), RawW'($urandom), RawW'($urandom), DtW'($urandom)};
    return it;
  endfunction

  function automatic logic signed [RawW-1:0] random_raw();
    if ($urandom_range(3) == 0) begin
      return RawW'($urandom_range(256) - 128);
    end
    return RawW'($urandom);
  endfunction

  function automatic imu_item_t random_sample();
    logic [DtW-1:0] dt;
    dt = ($urandom_range(3) == 0) ? DtW'($urandom) : DtW'($urandom_range(20000));
    return sample_item(random_raw(), random_raw(), random_raw(),
                       random_raw(), random_raw(), random_raw(), dt);
  endfunction

  task automatic send_item(input imu_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    calib_count_i <= it.count;
    accel_x_raw_i <= it.ax;
    accel_y_raw_i <= it.ay;
    accel_z_raw_i <= it.az;
    gyro_x_raw_i  <= it.gx;
    gyro_y_raw_i  <= it.gy;
    gyro_z_raw_i  <= it.gz;
    elapsed_us_i  <= it.dt;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    step_imu_model(it);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (integ_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic test_first_sample_drop();
    send_item(random_sample());
    send_item(sample_item('0, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic test_field_extremes();
    send_item(sample_item(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                          32'hffff_ffff));
    send_item(sample_item(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                          -16'sh8000, 32'hffff_ffff));
    send_item(sample_item(16'sh5555, -16'sh5556, 16'sh0003, 16'sh5555, -16'sh5556, 16'sh0001,
                          32'h5555_5555));
    send_item(sample_item(-16'sh5556, 16'sh5555, -16'sh0001, -16'sh5556, 16'sh5555, -16'sh0001,
                          32'haaaa_aaaa));
  endtask

  task automatic test_zero_count();
    send_item(start_item('0));
    send_item(sample_item(16'sh1234, -16'sh1234, 16'sh4000, 16'sh0100, -16'sh0100, 16'sh0007,
                          32'd10000));
  endtask

  task automatic test_calibration_saturation();
    // extreme offsets push the corrected z past full scale
    send_item(start_item(16'd1));
    send_item(sample_item(16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh0011,
                          32'd10000));
    send_item(sample_item(-16'sh8000, 16'sh7fff, 16'sh7fff, -16'sh8000, 16'sh7fff, 16'sh0000,
                          32'hffff_ffff));
  endtask

  task automatic test_calibration_restart();
    send_item(start_item(16'd3));
    send_item(random_sample());
    send_item(start_item(16'd2));
    send_item(random_sample());
    send_item(random_sample());
    send_item(random_sample());
    send_item(start_item(16'hffff));
    send_item(random_sample());
    send_item(random_sample());
    send_item(start_item('0));
    send_item(random_sample());
  endtask

  task automatic test_drain_pause();
    send_item(random_sample());
    wait_results_drained();
    send_item(random_sample());
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input int n_items);
    int sent;
    int pick;
    int n;
    sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        n = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
        send_item(start_item(CountW'(n)));
        sent++;
        for (int k = 0; k < n; k++) begin
          send_item(random_sample());
          sent++;
        end
      end else if (pick < 15) begin
        // abandoned calibration, cut short by a restart
        send_item(start_item(CountW'($urandom)));
        n = $urandom_range(3);
        for (int k = 0; k < n; k++) begin
          send_item(random_sample());
        end
        send_item(start_item('0));
        sent += n + 2;
      end else begin
        send_item(random_sample());
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportLimit) begin
        $display("mismatch %s: expected %h, actual %h", name, want, got);
      end
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    imu_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (integ_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("result transaction with nothing pending");
        end
      end else begin
        want = integ_q.pop_front();
        check_field("accel_x_corr", 64'(want.ax), 64'(unsigned'(accel_x_corr_o)));
        check_field("accel_y_corr", 64'(want.ay), 64'(unsigned'(accel_y_corr_o)));
        check_field("accel_z_corr", 64'(want.az), 64'(unsigned'(accel_z_corr_o)));
        check_field("angle_x", want.ang_x, angle_x_o);
        check_field("angle_y", want.ang_y, angle_y_o);
        check_field("angle_z", want.ang_z, angle_z_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[imu_bias_calibrate_and_gyro_integrate_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_sample_drop();
    test_field_extremes();
    test_zero_count();
    test_calibration_saturation();
    test_calibration_restart();
    test_drain_pause();
    test_random_traffic(0, 0, 400);
    test_random_traffic(47, 0, 400);
    test_random_traffic(0, 47, 400);
    test_random_traffic(19, 19, 400);
    wait_results_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && integ_q.size() == 0) begin
      $display("[imu_bias_calibrate_and_gyro_integrate_unit] OK");
    end else begin
      $display("[imu_bias_calibrate_and_gyro_integrate_unit] ERROR");
    end
    $finish;
  end

endmodule
